FILE: hw/rtl/ppzp_pkg.sv
package ppzp_pkg;

    // Default screen grid.
    localparam int SCREEN_WIDTH_DEF  = 100;
    localparam int SCREEN_HEIGHT_DEF = 40;

    // Widest cell address the job word carries (256 x 256 cells).
    localparam int ADDR_MAX_W = 16;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Item operation codes.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PLOT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Job kinds handed from front to back.
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_CLEAR = 2'd1;
    localparam logic [1:0] K_PLOT  = 2'd2;
    localparam logic [1:0] K_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_SIN_A        = 3'd0;
    localparam logic [2:0] REG_COS_A        = 3'd1;
    localparam logic [2:0] REG_SIN_B        = 3'd2;
    localparam logic [2:0] REG_COS_B        = 3'd3;
    localparam logic [2:0] REG_SIN_C        = 3'd4;
    localparam logic [2:0] REG_COS_C        = 3'd5;
    localparam logic [2:0] REG_PROJ_SCALE   = 3'd6;
    localparam logic [2:0] REG_DEPTH_OFFSET = 3'd7;

    localparam logic [7:0]  SPACE_CHAR = 8'd32;
    localparam logic [23:0] OOZ_MAX    = 24'hFFFFFF;

    typedef struct packed {
        logic signed [15:0] sin_a;
        logic signed [15:0] cos_a;
        logic signed [15:0] sin_b;
        logic signed [15:0] cos_b;
        logic signed [15:0] sin_c;
        logic signed [15:0] cos_c;
        logic [15:0]        proj_scale;
        logic [15:0]        depth_offset;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            kind;
        logic [ADDR_MAX_W-1:0] addr;
        logic [23:0]           ooz;
        logic [7:0]            chr;
    } t_job;

endpackage

FILE: hw/rtl/ppzp_ram.sv
module ppzp_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ppzp_queue.sv
module ppzp_queue
import ppzp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);

    t_job            r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QA_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

FILE: hw/rtl/ppzp_front.sv
module ppzp_front
import ppzp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    input  logic signed [15:0] i_pz,
    input  logic [7:0]         i_char,
    input  logic [11:0]        i_cell_addr,
    input  logic               i_init_done,
    input  logic               i_q_full,
    output logic               o_push,
    output t_job               o_job
);

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam logic signed [51:0] X_BIAS = 52'(SCREEN_WIDTH / 2 * 65536);
    localparam logic signed [51:0] Y_BIAS = 52'(SCREEN_HEIGHT / 2 * 65536);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_MAT   = 3'd1;
    localparam logic [2:0] F_DIV   = 3'd2;
    localparam logic [2:0] F_SCALE = 3'd3;
    localparam logic [2:0] F_SX    = 3'd4;
    localparam logic [2:0] F_SY    = 3'd5;
    localparam logic [2:0] F_IDX   = 3'd6;
    localparam logic [2:0] F_PUSH  = 3'd7;

    localparam logic [4:0] STEP_LAST = 5'd22;
    localparam logic [4:0] DIV_TOP   = 5'd24;

    logic [2:0]         r_state, n_state;
    logic [4:0]         r_step;
    logic signed [15:0] r_px, r_py, r_pz;
    logic [7:0]         r_char;
    logic signed [19:0] r_sasb, r_casb;
    logic signed [19:0] r_m00, r_m01, r_m02, r_m10, r_m11, r_m12, r_m21, r_m22;
    logic signed [51:0] r_acc;
    logic signed [23:0] r_xr, r_yr;
    logic [24:0]        r_z;
    logic [24:0]        r_rem;
    logic [24:0]        r_quo;
    logic [4:0]         r_dcnt;
    logic [23:0]        r_ooz;
    logic [23:0]        r_s;
    logic signed [35:0] r_xp, r_yp;
    t_job               r_job;

    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] mul_p, sh14, acc_sum, acc_sh, z_sum;
    logic               z_pos;
    logic               bit_in, q_bit;
    logic [25:0]        shifted;
    logic [26:0]        diff;
    logic [24:0]        q_final;
    logic signed [47:0] idx;
    logic               idx_ok;
    logic               accept;
    t_job               direct_job;

    // Truncating divide by 2^16, rounding toward zero.
    function automatic logic signed [35:0] trunc16(input logic signed [51:0] v);
        logic signed [51:0] q;
        begin
            q = v >>> 16;
            if (v[51] && (v[15:0] != 16'd0)) begin
                q = q + 52'sd1;
            end
            return q[35:0];
        end
    endfunction

    assign o_ready = i_init_done && (r_state == F_IDLE) && !i_q_full;
    assign accept  = i_valid && o_ready;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            F_MAT: begin
                case (r_step)
                    5'd0:  begin mul_a = 26'(i_cfg.sin_a); mul_b = 26'(i_cfg.sin_b); end
                    5'd1:  begin mul_a = 26'(i_cfg.cos_a); mul_b = 26'(i_cfg.sin_b); end
                    5'd2:  begin mul_a = 26'(i_cfg.cos_b); mul_b = 26'(i_cfg.cos_c); end
                    5'd3:  begin mul_a = 26'(i_cfg.cos_a); mul_b = 26'(i_cfg.sin_c); end
                    5'd4:  begin mul_a = 26'(r_sasb);      mul_b = 26'(i_cfg.cos_c); end
                    5'd5:  begin mul_a = 26'(i_cfg.sin_a); mul_b = 26'(i_cfg.sin_c); end
                    5'd6:  begin mul_a = 26'(r_casb);      mul_b = 26'(i_cfg.cos_c); end
                    5'd7:  begin mul_a = 26'(i_cfg.cos_b); mul_b = 26'(i_cfg.sin_c); end
                    5'd8:  begin mul_a = 26'(i_cfg.cos_a); mul_b = 26'(i_cfg.cos_c); end
                    5'd9:  begin mul_a = 26'(r_sasb);      mul_b = 26'(i_cfg.sin_c); end
                    5'd10: begin mul_a = 26'(i_cfg.sin_a); mul_b = 26'(i_cfg.cos_c); end
                    5'd11: begin mul_a = 26'(r_casb);      mul_b = 26'(i_cfg.sin_c); end
                    5'd12: begin mul_a = 26'(i_cfg.sin_a); mul_b = 26'(i_cfg.cos_b); end
                    5'd13: begin mul_a = 26'(i_cfg.cos_a); mul_b = 26'(i_cfg.cos_b); end
                    5'd14: begin mul_a = 26'(r_px);        mul_b = 26'(r_m00);       end
                    5'd15: begin mul_a = 26'(r_py);        mul_b = 26'(r_m01);       end
                    5'd16: begin mul_a = 26'(r_pz);        mul_b = 26'(r_m02);       end
                    5'd17: begin mul_a = 26'(r_px);        mul_b = 26'(r_m10);       end
                    5'd18: begin mul_a = 26'(r_py);        mul_b = 26'(r_m11);       end
                    5'd19: begin mul_a = 26'(r_pz);        mul_b = 26'(r_m12);       end
                    5'd20: begin mul_a = 26'(r_px);        mul_b = 26'(i_cfg.sin_b); end
                    5'd21: begin mul_a = 26'(r_py);        mul_b = 26'(r_m21);       end
                    5'd22: begin mul_a = 26'(r_pz);        mul_b = 26'(r_m22);       end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            F_SCALE: begin
                mul_a = $signed({10'd0, i_cfg.proj_scale});
                mul_b = $signed({2'd0, r_ooz});
            end
            F_SX: begin
                mul_a = $signed({2'd0, r_s});
                mul_b = 26'(r_xr);
            end
            F_SY: begin
                mul_a = $signed({2'd0, r_s});
                mul_b = 26'(r_yr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign sh14    = mul_p >>> 14;
    assign acc_sum = r_acc + mul_p;
    assign acc_sh  = acc_sum >>> 14;
    assign z_sum   = acc_sh + $signed({36'd0, i_cfg.depth_offset});
    assign z_pos   = !z_sum[51] && (z_sum != '0);

    // One quotient bit per cycle of 2^24 / z.
    assign bit_in  = (r_dcnt == DIV_TOP);
    assign shifted = {r_rem, bit_in};
    assign diff    = {1'b0, shifted} - {2'b00, r_z};
    assign q_bit   = !diff[26];
    assign q_final = {r_quo[23:0], q_bit};

    // Linear cell index and its bounds check.
    assign idx    = 48'(r_xp) + 48'(r_yp) * 48'(SCREEN_WIDTH);
    assign idx_ok = !idx[47] && (idx < 48'(CELLS));

    // Jobs that need no transform go straight to the queue.
    always_comb begin
        direct_job      = '0;
        direct_job.addr = ADDR_MAX_W'(i_cell_addr);
        case (i_op)
            OP_CLEAR: direct_job.kind = K_CLEAR;
            OP_READ:  direct_job.kind = (32'(i_cell_addr) < CELLS) ? K_READ : K_NONE;
            default:  direct_job.kind = K_NONE;
        endcase
    end

    assign o_push = (accept && (i_op != OP_PLOT)) || ((r_state == F_PUSH) && !i_q_full);
    assign o_job  = (r_state == F_PUSH) ? r_job : direct_job;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept && (i_op == OP_PLOT)) n_state = F_MAT;
            F_MAT:   if (r_step == STEP_LAST) n_state = z_pos ? F_DIV : F_PUSH;
            F_DIV:   if (r_dcnt == 5'd0) n_state = F_SCALE;
            F_SCALE: n_state = F_SX;
            F_SX:    n_state = F_SY;
            F_SY:    n_state = F_IDX;
            F_IDX:   n_state = F_PUSH;
            F_PUSH:  if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Transform datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_step <= '0;
                r_px   <= i_px;
                r_py   <= i_py;
                r_pz   <= i_pz;
                r_char <= i_char;
            end
            F_MAT: begin
                r_step <= r_step + 1'b1;
                case (r_step)
                    5'd0:  r_sasb <= sh14[19:0];
                    5'd1:  r_casb <= sh14[19:0];
                    5'd2:  r_m00  <= sh14[19:0];
                    5'd3:  r_m01  <= sh14[19:0];
                    5'd4:  r_m01  <= r_m01 + sh14[19:0];
                    5'd5:  r_m02  <= sh14[19:0];
                    5'd6:  r_m02  <= r_m02 - sh14[19:0];
                    5'd7:  r_m10  <= -sh14[19:0];
                    5'd8:  r_m11  <= sh14[19:0];
                    5'd9:  r_m11  <= r_m11 - sh14[19:0];
                    5'd10: r_m12  <= sh14[19:0];
                    5'd11: r_m12  <= r_m12 + sh14[19:0];
                    5'd12: r_m21  <= -sh14[19:0];
                    5'd13: r_m22  <= sh14[19:0];
                    5'd14, 5'd17, 5'd20: r_acc <= mul_p;
                    5'd16: r_xr <= acc_sh[23:0];
                    5'd19: r_yr <= acc_sh[23:0];
                    5'd22: begin
                        r_z    <= z_sum[24:0];
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_dcnt <= DIV_TOP;
                        r_job  <= '{kind: K_NONE, default: '0};
                    end
                    default: r_acc <= acc_sum;
                endcase
            end
            F_DIV: begin
                r_rem  <= q_bit ? diff[24:0] : shifted[24:0];
                r_quo  <= q_final;
                r_dcnt <= r_dcnt - 1'b1;
                r_ooz  <= q_final[24] ? OOZ_MAX : q_final[23:0];
            end
            F_SCALE: r_s <= mul_p[39:16];
            F_SX:    r_xp <= trunc16((mul_p <<< 1) + X_BIAS);
            F_SY:    r_yp <= trunc16(mul_p + Y_BIAS);
            F_IDX: begin
                r_job.kind <= idx_ok ? K_PLOT : K_NONE;
                r_job.addr <= idx_ok ? idx[ADDR_MAX_W-1:0] : '0;
                r_job.ooz  <= r_ooz;
                r_job.chr  <= r_char;
            end
            default: r_step <= r_step;
        endcase
    end

endmodule

FILE: hw/rtl/ppzp_back.sv
module ppzp_back
import ppzp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_init_done,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_stored,
    output logic [11:0] o_cell_pos,
    output logic [7:0]  o_char,
    output logic [23:0] o_depth
);

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);

    localparam logic [2:0] B_INIT  = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_CLEAR = 3'd2;
    localparam logic [2:0] B_WAIT  = 3'd3;
    localparam logic [2:0] B_EXEC  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_cnt;
    t_job          r_job;
    logic          r_ovalid;
    logic          r_stored;
    logic [11:0]   r_pos;
    logic [7:0]    r_char;
    logic [23:0]   r_depth;

    logic          sweeping, last, out_free, win, we;
    logic [AW-1:0] raddr, waddr;
    logic [23:0]   rd_depth, wr_depth;
    logic [7:0]    rd_char, wr_char;

    assign sweeping    = (r_state == B_INIT) || (r_state == B_CLEAR);
    assign last        = (r_cnt == AW'(CELLS - 1));
    assign out_free    = !r_ovalid || i_ready;
    assign win         = (r_job.ooz > rd_depth);
    assign o_pop       = (r_state == B_IDLE) && !i_q_empty;
    assign o_init_done = (r_state != B_INIT);

    // Store read-modify-write ports.
    assign raddr    = (r_state == B_IDLE) ? i_job.addr[AW-1:0] : r_job.addr[AW-1:0];
    assign we       = sweeping ||
                      ((r_state == B_EXEC) && out_free && (r_job.kind == K_PLOT) && win);
    assign waddr    = sweeping ? r_cnt : r_job.addr[AW-1:0];
    assign wr_depth = sweeping ? 24'd0 : r_job.ooz;
    assign wr_char  = sweeping ? SPACE_CHAR : r_job.chr;

    ppzp_ram #(.WIDTH(24), .DEPTH(CELLS)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_depth),
        .i_raddr (raddr),
        .o_rdata (rd_depth)
    );

    ppzp_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_char),
        .i_raddr (raddr),
        .o_rdata (rd_char)
    );

    // Job sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_INIT: if (last) n_state = B_IDLE;
            B_IDLE: begin
                if (!i_q_empty) begin
                    case (i_job.kind)
                        K_CLEAR: n_state = B_CLEAR;
                        K_PLOT:  n_state = B_WAIT;
                        K_READ:  n_state = B_WAIT;
                        default: n_state = B_EXEC;
                    endcase
                end
            end
            B_CLEAR: if (last) n_state = B_EXEC;
            B_WAIT:  n_state = B_EXEC;
            B_EXEC:  if (out_free) n_state = B_IDLE;
            default: n_state = B_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_INIT;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (sweeping) begin
                r_cnt <= last ? '0 : r_cnt + 1'b1;
            end
            if ((r_state == B_EXEC) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Job capture and result register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if ((r_state == B_EXEC) && out_free) begin
            case (r_job.kind)
                K_PLOT: begin
                    r_stored <= win;
                    r_pos    <= r_job.addr[11:0];
                    r_char   <= win ? r_job.chr : 8'd0;
                    r_depth  <= win ? r_job.ooz : 24'd0;
                end
                K_READ: begin
                    r_stored <= 1'b0;
                    r_pos    <= '0;
                    r_char   <= rd_char;
                    r_depth  <= rd_depth;
                end
                default: begin
                    r_stored <= 1'b0;
                    r_pos    <= '0;
                    r_char   <= '0;
                    r_depth  <= '0;
                end
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_stored   = r_stored;
    assign o_cell_pos = r_pos;
    assign o_char     = r_char;
    assign o_depth    = r_depth;

endmodule

FILE: hw/rtl/point_project_zbuffer_plot.sv
// Plot item: 23 shared-multiplier steps for matrix and rotation, the bit-serial reciprocal
// divider, 4 projection steps and one push in the front (a point whose depth is not
// positive is pushed at once as an empty job), then a depth read-modify-write in the back;
// the front takes no new item until its plot is pushed. A clear item writes one store
// entry per cycle. After reset a pass clears all SCREEN_WIDTH*SCREEN_HEIGHT entries
// (4000 by default) with tready low; configuration is reset too.
module point_project_zbuffer_plot
import ppzp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // px[15:0], py[31:16], pz[47:32], plot_char[55:48], cell_addr[67:56], zero pad
    input  logic [71:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // cell_pos[11:0], out_char[19:12], out_depth[43:20], zero pad
    output logic [47:0] o_m_axis_tdata,
    // stored[0]
    output logic [0:0]  o_m_axis_tuser
);

    t_cfg        r_cfg;
    logic        q_push, q_pop, q_full, q_empty, init_done;
    t_job        push_job, head_job;
    logic        stored;
    logic [11:0] cell_pos;
    logic [7:0]  out_char;
    logic [23:0] out_depth;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sin_a        <= 16'sd0;
            r_cfg.cos_a        <= 16'sd16384;
            r_cfg.sin_b        <= 16'sd0;
            r_cfg.cos_b        <= 16'sd16384;
            r_cfg.sin_c        <= 16'sd0;
            r_cfg.cos_c        <= 16'sd16384;
            r_cfg.proj_scale   <= 16'd10240;
            r_cfg.depth_offset <= 16'd15360;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SIN_A:        r_cfg.sin_a        <= i_cfg_wdata;
                REG_COS_A:        r_cfg.cos_a        <= i_cfg_wdata;
                REG_SIN_B:        r_cfg.sin_b        <= i_cfg_wdata;
                REG_COS_B:        r_cfg.cos_b        <= i_cfg_wdata;
                REG_SIN_C:        r_cfg.sin_c        <= i_cfg_wdata;
                REG_COS_C:        r_cfg.cos_c        <= i_cfg_wdata;
                REG_PROJ_SCALE:   r_cfg.proj_scale   <= i_cfg_wdata;
                REG_DEPTH_OFFSET: r_cfg.depth_offset <= i_cfg_wdata;
                default:          r_cfg.sin_a        <= r_cfg.sin_a;
            endcase
        end
    end

    ppzp_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_px        (i_s_axis_tdata[15:0]),
        .i_py        (i_s_axis_tdata[31:16]),
        .i_pz        (i_s_axis_tdata[47:32]),
        .i_char      (i_s_axis_tdata[55:48]),
        .i_cell_addr (i_s_axis_tdata[67:56]),
        .i_init_done (init_done),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    ppzp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    ppzp_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_init_done (init_done),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_stored    (stored),
        .o_cell_pos  (cell_pos),
        .o_char      (out_char),
        .o_depth     (out_depth)
    );

    assign o_m_axis_tdata = {4'd0, out_depth, out_char, cell_pos};
    assign o_m_axis_tuser = stored;

endmodule

FILE: hw/rtl/ppzp_checker.sv
module ppzp_checker
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // No result beat is shown in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A result beat is not withdrawn while stalled.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A stored point always carries a nonzero reciprocal depth.
    a_stored_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> (o_m_axis_tdata[43:20] != 24'd0))
        else $error("stored point with zero depth");

    // A plot that hits a cell but loses the depth test reports no character or depth.
    a_lose_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] && (o_m_axis_tdata[11:0] != 12'd0)
        |-> (o_m_axis_tdata[43:12] == 32'd0))
        else $error("losing plot carries data");

endmodule

bind point_project_zbuffer_plot ppzp_checker u_ppzp_checker (.*);
